// ===== hdl/lcdse_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdse_pkg
// shared types and constants of the serial lcd controller emulation
// ----------------------------------------------------------------------------
package lcdse_pkg;

   typedef logic [7:0] byte_type;

   // memory geometry
   localparam int TEXT_DEPTH  = 64;
   localparam int GLYPH_DEPTH = 128;
   localparam int GRAPH_DEPTH = 1024;
   localparam int FONT_DEPTH  = 1520;
   localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
   localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
   localparam int GRAPH_AW    = $clog2(GRAPH_DEPTH);
   localparam int FONT_AW     = $clog2(FONT_DEPTH);

   // serial link sync bytes
   localparam byte_type SYNC_WCMD  = 8'hF8;
   localparam byte_type SYNC_WDATA = 8'hFA;
   localparam byte_type SYNC_RCMD  = 8'hFC;
   localparam byte_type SYNC_RDATA = 8'hFE;

   // character handling
   localparam byte_type CHAR_LO     = 8'h20;
   localparam byte_type CHAR_HI     = 8'h7E;
   localparam byte_type SPACE_CHAR  = 8'h20;
   localparam byte_type GLYPH_MASK  = 8'hF6;
   localparam byte_type GLYPH_SEL   = 8'h06;
   localparam logic [6:0] FONT_GLYPHS = 7'd95;

   localparam byte_type FS_RESET = 8'h26;

endpackage

// ===== hdl/lcdse_ram.sv =====
// ----------------------------------------------------------------------------
// lcdse_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lcdse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lcd_controller_serial_emulation_top.sv =====
// ----------------------------------------------------------------------------
// lcd_controller_serial_emulation_top
// serial link front end of a 128x64 text/graphic lcd controller that turns
// link bytes into memory updates and a stream of redrawn 8-pixel bytes
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  req_      in         req_valid/stall    operation, serial_byte, font_char,
//                                          font_row, font_bits
//  rsp_      out        rsp_valid/stall    x_byte, y_pixel, pixel_bits,
//                                          last_of_run
//
//  one request at a time; req_stall is low only while the sequencer idles
//  sync bytes, nibbles, commands, font/glyph writes: taken in S_IDLE alone
//  graphic data byte: S_RD0..S_RD3, S_EMIT; text data byte: S_TXT_RD0..RD2 (and
//  S_TXT_WR2 when a glyph pair is broken), then S_RD0..S_RD3, S_EMIT per redrawn
//  byte (up to 32), set by the single read port of the text ram
//  reset and the clear command run a clearing pass over the rams
//  rsp_stall holds the sequencer only when the output register is occupied
//
module lcd_controller_serial_emulation_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  lcdse_pkg::byte_type  req_serial_byte,
   input  logic [6:0]           req_font_char,
   input  logic [3:0]           req_font_row,
   input  lcdse_pkg::byte_type  req_font_bits,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_x_byte,
   output logic [5:0]           rsp_y_pixel,
   output lcdse_pkg::byte_type  rsp_pixel_bits,
   output logic                 rsp_last_of_run
);
   import lcdse_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_TXT_RD0, S_TXT_RD1, S_TXT_RD2, S_TXT_WR2,
      S_RD0, S_RD1, S_RD2, S_RD3, S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      M_IDLE, M_WCMD, M_WDATA, M_RCMD, M_RDATA
   } mode_type;

   typedef enum logic [1:0] {
      T_TEXT, T_GLYPH, T_GRAPHIC
   } target_type;

   typedef struct packed {
      logic [3:0] x;
      logic [6:0] y;
   } cursor_type;

   // command slots, by highest set bit
   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_HOME  = 3'd1;
   localparam logic [2:0] CMD_FUNC  = 3'd5;
   localparam logic [2:0] CMD_CGRAM = 3'd6;
   localparam logic [2:0] CMD_DDRAM = 3'd7;
   localparam logic [2:0] CMD_GDRAM = 3'd7;

   // highest set bit: [3] = any bit set, [2:0] = its index
   function automatic logic [3:0] top_bit(input byte_type v);
      logic [3:0] res;
      res = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (v[i]) begin
            res = {1'b1, 3'(i)};
         end
      end
      return res;
   endfunction

   // step right; at the end of a line jump to the interleaved next line
   function automatic cursor_type adv_cursor(input cursor_type c);
      cursor_type n;
      logic [7:0] t;
      n.x = c.x + 4'd1;
      n.y = c.y;
      t = {1'b0, c.y} + 8'd32;
      if (n.x == 4'd0) begin
         if (t == 8'd64) begin
            t = 8'd16;
         end else if (t == 8'd80) begin
            t = 8'd0;
         end
         n.y = t[6:0];
      end
      return n;
   endfunction

   function automatic logic is_char(input byte_type v);
      return (v >= CHAR_LO) && (v <= CHAR_HI);
   endfunction

   // sequencer and link state
   state_type    state_ff, state_in;
   logic [GRAPH_AW-1:0] clr_cnt_ff, clr_cnt_in;
   mode_type     mode_ff, mode_in;
   logic         nib_ff, nib_in;
   logic [3:0]   high_nib_ff, high_nib_in;
   cursor_type   cur_ff, cur_in;
   logic         addr_row_ff, addr_row_in;
   target_type   target_ff, target_in;
   byte_type     fs_ff, fs_in;
   // entry mode, display control and reverse do not alter the pixel stream

   // redraw run control
   logic [3:0]   run_x_ff, run_x_in;
   logic [5:0]   y0_ff, y0_in;
   logic [3:0]   r_ff, r_in;
   logic         sub_ff, sub_in;
   logic         pair_ff, pair_in;
   logic         one_ff, one_in;
   logic         pend2_ff, pend2_in;

   // working payload
   byte_type     data_ff, data_in;
   byte_type     old_ff, old_in;
   byte_type     t0_ff, t0_in;
   logic         gsel_ff, gsel_in;
   logic         fok_ff, fok_in;
   byte_type     bits_ff, bits_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [3:0]   rsp_x_ff, rsp_x_in;
   logic [5:0]   rsp_y_ff, rsp_y_in;
   byte_type     rsp_bits_ff, rsp_bits_in;
   logic         rsp_last_ff, rsp_last_in;

   // ram ports
   logic                 text_we, glyph_we, graph_we, font_we;
   logic [TEXT_AW-1:0]   text_wa, text_ra;
   logic [GLYPH_AW-1:0]  glyph_wa, glyph_ra;
   logic [GRAPH_AW-1:0]  graph_wa, graph_ra;
   logic [FONT_AW-1:0]   font_wa, font_ra;
   byte_type             text_wd, glyph_wd, graph_wd;
   byte_type             text_rd, glyph_rd, graph_rd, font_rd;

   logic       accept, out_load, r_last;
   byte_type   full_byte, ch, glyph_code, ts;
   logic [3:0] cmd_top;
   logic [3:0] x_c, xs_c, xs_w;
   logic [5:0] y_c;
   logic [1:0] row_w;
   logic [7:0] ch_index;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign full_byte = {high_nib_ff, req_serial_byte[7:4]};
   assign cmd_top   = top_bit(full_byte);

   // current redraw position: in a pair run the even column goes first
   assign x_c  = (pair_ff && !sub_ff) ? {run_x_ff[3:1], 1'b0} : run_x_ff;
   assign xs_c = {x_c[3:1], 1'b0};
   assign y_c  = y0_ff + {2'b00, r_ff};
   assign xs_w = {run_x_ff[3:1], 1'b0};
   assign row_w = y0_ff[5:4];

   // character shown at x_c: even column from t0, odd from the text ram read data
   assign ch         = x_c[0] ? text_rd : t0_ff;
   assign glyph_code = text_rd & GLYPH_MASK & GLYPH_SEL;
   assign ch_index   = ch - CHAR_LO;
   assign r_last     = one_ff || ((r_ff == 4'hF) && (!pair_ff || sub_ff));
   assign ts         = run_x_ff[0] ? text_rd : data_ff;

   // read addresses
   always_comb begin
      case (state_ff)
         S_TXT_RD0: text_ra = {row_w, run_x_ff};
         S_TXT_RD1: text_ra = {row_w, xs_w};
         S_RD0:     text_ra = {y_c[5:4], xs_c};
         default:   text_ra = {y_c[5:4], xs_c[3:1], 1'b1};
      endcase
   end
   assign glyph_ra = {glyph_code[2:1], y_c[3:0], x_c[0]};
   assign font_ra  = {ch_index[6:0], y_c[3:0]};
   assign graph_ra = {y_c, x_c};

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      mode_in     = mode_ff;
      nib_in      = nib_ff;
      high_nib_in = high_nib_ff;
      cur_in      = cur_ff;
      addr_row_in = addr_row_ff;
      target_in   = target_ff;
      fs_in       = fs_ff;
      run_x_in    = run_x_ff;
      y0_in       = y0_ff;
      r_in        = r_ff;
      sub_in      = sub_ff;
      pair_in     = pair_ff;
      one_in      = one_ff;
      pend2_in    = pend2_ff;
      data_in     = data_ff;
      old_in      = old_ff;
      t0_in       = t0_ff;
      gsel_in     = gsel_ff;
      fok_in      = fok_ff;
      bits_in     = bits_ff;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_bits_in = rsp_bits_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;

      text_we  = 1'b0;
      text_wa  = {row_w, run_x_ff};
      text_wd  = data_ff;
      glyph_we = 1'b0;
      glyph_wa = {cur_ff.y[5:0], cur_ff.x[0]};
      glyph_wd = full_byte;
      graph_we = 1'b0;
      graph_wa = {cur_ff.y[5:0], cur_ff.x};
      graph_wd = full_byte;
      font_we  = 1'b0;
      font_wa  = {req_font_char, req_font_row};

      unique case (state_ff)
         S_CLEAR: begin
            text_we  = 1'b1;
            text_wa  = clr_cnt_ff[TEXT_AW-1:0];
            text_wd  = SPACE_CHAR;
            glyph_we = 1'b1;
            glyph_wa = clr_cnt_ff[GLYPH_AW-1:0];
            glyph_wd = '0;
            graph_we = 1'b1;
            graph_wa = clr_cnt_ff;
            graph_wd = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_operation) begin
                  font_we = (req_font_char < FONT_GLYPHS);
               end else if (req_serial_byte == SYNC_WCMD || req_serial_byte == SYNC_WDATA ||
                            req_serial_byte == SYNC_RCMD || req_serial_byte == SYNC_RDATA) begin
                  nib_in = 1'b0;
                  if (req_serial_byte == SYNC_WCMD) begin
                     mode_in = M_WCMD;
                  end else if (req_serial_byte == SYNC_WDATA) begin
                     mode_in = M_WDATA;
                     addr_row_in = 1'b1;
                  end else if (req_serial_byte == SYNC_RCMD) begin
                     mode_in = M_RCMD;
                  end else begin
                     mode_in = M_RDATA;
                  end
               end else if (!nib_ff) begin
                  high_nib_in = req_serial_byte[7:4];
                  nib_in = 1'b1;
               end else begin
                  nib_in = 1'b0;
                  r_in     = '0;
                  sub_in   = 1'b0;
                  pair_in  = 1'b0;
                  pend2_in = 1'b0;
                  run_x_in = cur_ff.x;
                  y0_in    = cur_ff.y[5:0];
                  data_in  = full_byte;
                  if (mode_ff == M_WCMD && cmd_top[3]) begin
                     if (cmd_top[2:0] == CMD_FUNC) begin
                        fs_in = full_byte;
                     end else if (!fs_ff[2]) begin
                        unique case (cmd_top[2:0])
                           CMD_CLEAR: begin
                              cur_in = '0;
                              clr_cnt_in = '0;
                              state_in = S_CLEAR;
                           end
                           CMD_HOME: cur_in = '0;
                           CMD_CGRAM: begin
                              cur_in.x = '0;
                              cur_in.y = {1'b0, full_byte[5:0]};
                              target_in = T_GLYPH;
                           end
                           CMD_DDRAM: begin
                              cur_in.x = {full_byte[2:0], 1'b0};
                              cur_in.y = {1'b0, full_byte[3], full_byte[4], 4'b0000};
                              target_in = T_TEXT;
                           end
                           default: ;
                        endcase
                     end else if (cmd_top[2:0] == CMD_GDRAM) begin
                        // graphic address: row byte first, then column byte
                        if (addr_row_ff) begin
                           cur_in.y = full_byte[6:0];
                           addr_row_in = 1'b0;
                        end else begin
                           if (full_byte[3]) begin
                              cur_in.y = cur_ff.y + 7'd32;
                           end
                           cur_in.x = {full_byte[2:0], 1'b0};
                           addr_row_in = 1'b1;
                        end
                        target_in = T_GRAPHIC;
                     end
                  end else if (mode_ff == M_WDATA) begin
                     case (target_ff)
                        T_TEXT: begin
                           one_in = 1'b0;
                           cur_in = adv_cursor(cur_ff);
                           state_in = S_TXT_RD0;
                        end
                        T_GLYPH: begin
                           glyph_we = 1'b1;
                           if (cur_ff.x[0]) begin
                              cur_in.x = '0;
                              cur_in.y = {1'b0, cur_ff.y[5:0] + 6'd1};
                           end else begin
                              cur_in.x = 4'd1;
                           end
                        end
                        T_GRAPHIC: begin
                           if (fs_ff[1]) begin
                              graph_we = 1'b1;
                              one_in = 1'b1;
                              cur_in = adv_cursor(cur_ff);
                              state_in = S_RD0;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         S_TXT_RD0: state_in = S_TXT_RD1;
         S_TXT_RD1: begin
            old_in = text_rd;
            state_in = S_TXT_RD2;
         end
         S_TXT_RD2: begin
            // store the character, then decide which columns to redraw
            text_we = 1'b1;
            state_in = S_IDLE;
            if (ts == '0) begin
               if (run_x_ff[0]) begin
                  pair_in = 1'b1;
                  state_in = S_RD0;
               end
            end else if (old_ff == '0 && !run_x_ff[0]) begin
               // a double-wide glyph pair is broken: the right half turns blank
               state_in = S_TXT_WR2;
               if (is_char(data_ff)) begin
                  pend2_in = 1'b1;
               end else begin
                  run_x_in = run_x_ff + 4'd1;
               end
            end else if (is_char(data_ff)) begin
               state_in = S_RD0;
            end
         end
         S_TXT_WR2: begin
            text_we = 1'b1;
            text_wa = {row_w, run_x_ff[3:1], 1'b1};
            text_wd = SPACE_CHAR;
            state_in = S_RD0;
         end
         S_RD0: state_in = S_RD1;
         S_RD1: begin
            t0_in = text_rd;
            state_in = S_RD2;
         end
         S_RD2: begin
            gsel_in = (t0_ff == '0);
            fok_in  = is_char(ch);
            state_in = S_RD3;
         end
         S_RD3: begin
            bits_in = (gsel_ff ? glyph_rd : (fok_ff ? font_rd : '0)) ^ graph_rd;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_c;
               rsp_y_in     = y_c;
               rsp_bits_in  = bits_ff;
               rsp_last_in  = r_last && !pend2_ff;
               if (!r_last) begin
                  state_in = S_RD0;
                  if (pair_ff && !sub_ff) begin
                     sub_in = 1'b1;
                  end else begin
                     sub_in = 1'b0;
                     r_in = r_ff + 4'd1;
                  end
               end else if (pend2_ff) begin
                  // second run: the blanked right-hand column
                  pend2_in = 1'b0;
                  run_x_in = run_x_ff + 4'd1;
                  sub_in   = 1'b0;
                  r_in     = '0;
                  state_in = S_RD0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         mode_ff      <= M_IDLE;
         nib_ff       <= 1'b0;
         high_nib_ff  <= '0;
         cur_ff       <= '0;
         addr_row_ff  <= 1'b1;
         target_ff    <= T_TEXT;
         fs_ff        <= FS_RESET;
         sub_ff       <= 1'b0;
         pair_ff      <= 1'b0;
         one_ff       <= 1'b0;
         pend2_ff     <= 1'b0;
         r_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         mode_ff      <= mode_in;
         nib_ff       <= nib_in;
         high_nib_ff  <= high_nib_in;
         cur_ff       <= cur_in;
         addr_row_ff  <= addr_row_in;
         target_ff    <= target_in;
         fs_ff        <= fs_in;
         sub_ff       <= sub_in;
         pair_ff      <= pair_in;
         one_ff       <= one_in;
         pend2_ff     <= pend2_in;
         r_ff         <= r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_x_ff    <= run_x_in;
      y0_ff       <= y0_in;
      data_ff     <= data_in;
      old_ff      <= old_in;
      t0_ff       <= t0_in;
      gsel_ff     <= gsel_in;
      fok_ff      <= fok_in;
      bits_ff     <= bits_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_byte      = rsp_x_ff;
   assign rsp_y_pixel     = rsp_y_ff;
   assign rsp_pixel_bits  = rsp_bits_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // character codes, one row of 16 per text line
   lcdse_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
      .clock(clock), .wr_en(text_we), .wr_addr(text_wa), .wr_data(text_wd),
      .rd_addr(text_ra), .rd_data(text_rd)
   );

   // user glyphs, 16x16 each, two bytes per row
   lcdse_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph (
      .clock(clock), .wr_en(glyph_we), .wr_addr(glyph_wa), .wr_data(glyph_wd),
      .rd_addr(glyph_ra), .rd_data(glyph_rd)
   );

   // graphic overlay, 64 rows of 16 bytes
   lcdse_ram #(.WIDTH(8), .DEPTH(GRAPH_DEPTH)) u_graph (
      .clock(clock), .wr_en(graph_we), .wr_addr(graph_wa), .wr_data(graph_wd),
      .rd_addr(graph_ra), .rd_data(graph_rd)
   );

   // 8x16 font, loaded through font requests
   lcdse_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
      .clock(clock), .wr_en(font_we), .wr_addr(font_wa), .wr_data(req_font_bits),
      .rd_addr(font_ra), .rd_data(font_rd)
   );

   // clearing pass follows every reset
   a_reset_sweep: assert property (@(posedge clock)
      $fell(reset) |-> state_ff == S_CLEAR)
      else $error("no clearing pass after reset");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten");

   // a pair run always belongs to an odd column
   a_pair_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD0 && pair_ff) |-> run_x_ff[0])
      else $error("pair run on even column");

   // after the last byte of a request the sequencer is free again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_last_in) |=> state_ff == S_IDLE)
      else $error("work continues after last byte");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the serial lcd controller emulation: loads the font
// glyphs that the bench draws, runs a short directed list of requests and
// then random command and data sequences, and compares every redrawn pixel
// byte with a predictor
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdse_pkg::*;

   // request kinds
   localparam logic OP_LINK = 1'b0;
   localparam logic OP_FONT = 1'b1;

   // command codes, basic set
   localparam byte_type CMD_CLEAR   = 8'h01;
   localparam byte_type CMD_HOME    = 8'h02;
   localparam byte_type CMD_ENTRY   = 8'h04;
   localparam byte_type CMD_DISPLAY = 8'h08;
   localparam byte_type CMD_SHIFT   = 8'h10;
   localparam byte_type CMD_FUNC    = 8'h20;
   localparam byte_type CMD_CGRAM   = 8'h40;
   localparam byte_type CMD_DDRAM   = 8'h80;
   // command codes, extended set
   localparam byte_type CMD_STANDBY = 8'h01;
   localparam byte_type CMD_SCROLL  = 8'h02;
   localparam byte_type CMD_REVERSE = 8'h04;
   localparam byte_type CMD_GDRAM   = 8'h80;
   // function set bits
   localparam byte_type FS_GRAPH = 8'h02;
   localparam byte_type FS_RE    = 8'h04;

   localparam int N_RANDOM   = 320;
   localparam int N_QUIET    = 60;
   localparam int HOLD_AT    = 200;
   localparam int HOLD_LEN   = 400;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYC  = 200;

   typedef enum logic [2:0] {
      LINK_IDLE, LINK_WCMD, LINK_WDATA, LINK_RCMD, LINK_RDATA
   } link_type;
   typedef enum logic [1:0] {TGT_TEXT, TGT_GLYPH, TGT_GRAPHIC} target_type;

   typedef struct packed {
      logic [3:0] x;
      logic [5:0] y;
      byte_type   bits;
      logic       lastrun;
   } pix_type;

   typedef struct {
      logic       op;
      byte_type   sb;
      logic [6:0] fc;
      logic [3:0] fr;
      byte_type   fb;
      bit         typed;
      pix_type    want;
   } row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_operation;
   byte_type   req_serial_byte;
   logic [6:0] req_font_char;
   logic [3:0] req_font_row;
   byte_type   req_font_bits;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [3:0] rsp_x_byte;
   logic [5:0] rsp_y_pixel;
   byte_type   rsp_pixel_bits;
   logic       rsp_last_of_run;

   lcd_controller_serial_emulation_top DUT (.*);

   // predictor state
   link_type   lk_mode;
   bit         nib_phase;
   logic [3:0] nib_hi;
   logic [3:0] cur_x;
   logic [6:0] cur_y;
   bit         addr_row;
   target_type tgt;
   byte_type   fs_reg, em_reg, dc_reg;
   bit         rev_flag;
   byte_type   text_mem [TEXT_DEPTH];
   byte_type   glyph_mem [GLYPH_DEPTH];
   byte_type   graph_mem [GRAPH_DEPTH];
   byte_type   font_mem [FONT_DEPTH];

   pix_type redraw_buf[$];   // results of the request being predicted
   pix_type pending_pix[$];  // expected pixel bytes not yet seen
   row_type dir_rows[$];

   int  errors = 0;
   int  idle_cycles = 0;
   int  hold_cnt = 0;
   int  stall_left = 0;
   bit  quiet = 0;
   int  rand_cnt = 0;

   // ------------------------------------------------------------------ clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------- predictor
   function automatic void clear_mems();
      for (int i = 0; i < TEXT_DEPTH; i++) text_mem[i] = SPACE_CHAR;
      for (int i = 0; i < GLYPH_DEPTH; i++) glyph_mem[i] = '0;
      for (int i = 0; i < GRAPH_DEPTH; i++) graph_mem[i] = '0;
   endfunction

   function automatic void pred_reset();
      lk_mode = LINK_IDLE;
      nib_phase = 0;
      nib_hi = '0;
      cur_x = '0;
      cur_y = '0;
      addr_row = 1;
      tgt = TGT_TEXT;
      fs_reg = FS_RESET;
      em_reg = 8'h02;
      dc_reg = '0;
      rev_flag = 0;
      clear_mems();
   endfunction

   // move right, then wrap to the next text line pair
   function automatic void step_cursor();
      int unsigned y;
      cur_x = cur_x + 4'd1;
      if (cur_x == 0) begin
         y = cur_y + 32;
         if (y == 64) y = 16;
         else if (y == 80) y = 0;
         cur_y = y[6:0];
      end
   endfunction

   function automatic void redraw_byte(int unsigned x, int unsigned y);
      int unsigned row, off, xs, code, ch;
      byte_type bits;
      pix_type p;
      row = (y >> 4) & 3;
      off = y & 15;
      xs = x & 14;
      bits = '0;
      x = x & 15;
      y = y & 63;
      if (text_mem[row*16 + xs] == 0) begin
         // glyph ram character: selector from the odd cell
         code = text_mem[row*16 + xs + 1] & GLYPH_MASK & GLYPH_SEL;
         bits = glyph_mem[((code*8 + off)*2 + (x & 1)) & 127];
      end else begin
         ch = text_mem[row*16 + x];
         if (ch >= CHAR_LO && ch <= CHAR_HI) bits = font_mem[(ch - CHAR_LO)*16 + off];
      end
      bits = bits ^ graph_mem[y*16 + x];
      if (redraw_buf.size() < 32) begin
         p.x = x[3:0];
         p.y = y[5:0];
         p.bits = bits;
         p.lastrun = 1'b0;
         redraw_buf.push_back(p);
      end
   endfunction

   function automatic void put_text(byte_type d);
      int unsigned x, xs, y0, row;
      byte_type old;
      x = cur_x;
      xs = x & 14;
      y0 = cur_y & 63;
      row = y0 >> 4;
      old = text_mem[row*16 + x];
      text_mem[row*16 + x] = d;
      if (text_mem[row*16 + xs] == 0) begin
         if (xs != x)
            for (int r = 0; r < 16; r++) begin
               redraw_byte(xs, (y0 + r) & 63);
               redraw_byte(x, (y0 + r) & 63);
            end
      end else begin
         if (d >= CHAR_LO && d <= CHAR_HI)
            for (int r = 0; r < 16; r++) redraw_byte(x, (y0 + r) & 63);
         if (old == 0 && xs == x) begin
            text_mem[row*16 + x + 1] = SPACE_CHAR;
            for (int r = 0; r < 16; r++) redraw_byte(x + 1, (y0 + r) & 63);
         end
      end
      step_cursor();
   endfunction

   function automatic void put_glyph(byte_type d);
      glyph_mem[((cur_y & 63)*2 + cur_x[0]) & 127] = d;
      if (cur_x[0]) begin
         cur_x = '0;
         cur_y = (cur_y + 7'd1) & 7'h3F;
      end else begin
         cur_x = 4'd1;
      end
   endfunction

   function automatic void put_graphic(byte_type d);
      if ((fs_reg & FS_GRAPH) == 0) return;
      graph_mem[(cur_y & 63)*16 + cur_x] = d;
      redraw_byte(cur_x, cur_y & 63);
      step_cursor();
   endfunction

   function automatic void do_command(byte_type cmd);
      int hb;
      logic [6:0] a;
      hb = -1;
      for (int b = 0; b < 8; b++) if (cmd[b]) hb = b;
      if (hb < 0) return;
      if (hb == 5) begin
         fs_reg = cmd;
         return;
      end
      if ((fs_reg & FS_RE) == 0) begin
         case (hb)
            0: begin
               cur_x = '0; cur_y = '0;
               em_reg = em_reg | 8'h02;
               clear_mems();
            end
            1: begin cur_x = '0; cur_y = '0; end
            2: em_reg = cmd;
            3: dc_reg = cmd;
            6: begin
               cur_x = '0;
               cur_y = {1'b0, cmd[5:0]};
               tgt = TGT_GLYPH;
            end
            7: begin
               cur_x = {cmd[2:0], 1'b0};
               cur_y = 7'(cmd[4] * 16 + cmd[3] * 32);
               tgt = TGT_TEXT;
            end
            default: ;
         endcase
      end else if (hb == 2) begin
         rev_flag = ~rev_flag;
      end else if (hb == 7) begin
         a = cmd[6:0];
         if (addr_row) begin
            cur_y = a;
            addr_row = 0;
         end else begin
            if (a[3]) cur_y = cur_y + 7'd32;
            cur_x = {a[2:0], 1'b0};
            addr_row = 1;
         end
         tgt = TGT_GRAPHIC;
      end
   endfunction

   function automatic bit is_sync(byte_type b);
      return b == SYNC_WCMD || b == SYNC_WDATA || b == SYNC_RCMD || b == SYNC_RDATA;
   endfunction

   // characters the bench may write: any outside the printable range, else low nibble zero or the highest one
   function automatic bit drawable(byte_type c);
      if (c < CHAR_LO || c > CHAR_HI) return 1;
      return (c[3:0] == 4'h0) || (c == CHAR_HI);
   endfunction

   function automatic void predict_request(logic op, byte_type b, logic [6:0] fc,
                                           logic [3:0] fr, byte_type fb);
      byte_type full;
      pix_type p;
      redraw_buf.delete();
      if (op == OP_FONT) begin
         if (fc < FONT_GLYPHS) font_mem[fc*16 + fr] = fb;
         return;
      end
      if (is_sync(b)) begin
         lk_mode = (b == SYNC_WCMD) ? LINK_WCMD : (b == SYNC_WDATA) ? LINK_WDATA :
                   (b == SYNC_RCMD) ? LINK_RCMD : LINK_RDATA;
         nib_phase = 0;
         if (lk_mode == LINK_WDATA) addr_row = 1;
         return;
      end
      if (!nib_phase) begin
         nib_hi = b[7:4];
         nib_phase = 1;
         return;
      end
      nib_phase = 0;
      full = {nib_hi, b[7:4]};
      if (lk_mode == LINK_WCMD) do_command(full);
      else if (lk_mode == LINK_WDATA) begin
         case (tgt)
            TGT_TEXT:    put_text(full);
            TGT_GLYPH:   put_glyph(full);
            TGT_GRAPHIC: put_graphic(full);
            default: ;
         endcase
      end
      if (redraw_buf.size() > 0) begin
         p = redraw_buf[redraw_buf.size()-1];
         p.lastrun = 1'b1;
         redraw_buf[redraw_buf.size()-1] = p;
      end
   endfunction

   // ---------------------------------------------------------------- sender
   task automatic send_req(input logic op, input byte_type sb, input logic [6:0] fc,
                           input logic [3:0] fr, input byte_type fb,
                           input bit typed, input pix_type want);
      bit done;
      // random idle burst before the request
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_serial_byte <= sb;
      req_font_char <= fc;
      req_font_row <= fr;
      req_font_bits <= fb;
      done = 0;
      while (!done) begin
         @(posedge clock);
         if (!req_stall) done = 1;
      end
      // request taken: work out what it redraws
      predict_request(op, sb, fc, fr, fb);
      if (typed) pending_pix.push_back(want);
      else foreach (redraw_buf[i]) pending_pix.push_back(redraw_buf[i]);
      @(negedge clock);
   endtask

   task automatic count_rand();
      rand_cnt++;
      // long receiver hold-off partway through the random part
      if (rand_cnt == HOLD_AT) hold_cnt = HOLD_LEN;
      if (rand_cnt == N_RANDOM - N_QUIET) quiet = 1;
   endtask

   task automatic send_link(input byte_type b);
      pix_type none;
      byte_type sb, full;
      none = '0;
      sb = b;
      full = {nib_hi, b[7:4]};
      // a text character without a loaded glyph becomes the one at low nibble zero
      if (!is_sync(b) && nib_phase && lk_mode == LINK_WDATA && tgt == TGT_TEXT &&
          !drawable(full))
         sb = {4'h0, b[3:0]};
      send_req(OP_LINK, sb, 7'($urandom), 4'($urandom), 8'($urandom), 0, none);
      count_rand();
   endtask

   // nibble carrier with random low bits, never mistaken for a sync byte
   function automatic byte_type carrier(logic [3:0] nib);
      logic [3:0] lo;
      lo = 4'($urandom);
      if (nib == 4'hF && lo[3] && !lo[0]) lo[0] = 1'b1;
      return {nib, lo};
   endfunction

   task automatic send_pair(input byte_type v);
      send_link(carrier(v[7:4]));
      send_link(carrier(v[3:0]));
   endtask

   task automatic send_font(input logic [6:0] fc);
      pix_type none;
      none = '0;
      send_req(OP_FONT, 8'($urandom), fc, 4'($urandom), 8'($urandom), 0, none);
      count_rand();
   endtask

   function automatic byte_type rand_command();
      byte_type r;
      r = 8'($urandom);
      case ($urandom_range(0, 13))
         0:  return ($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_HOME;
         1:  return CMD_ENTRY | (r & 8'h03);
         2:  return CMD_DISPLAY | (r & 8'h07);
         3:  return CMD_SHIFT | (r & 8'h0F);
         // function set: mostly graphic on, random extended bit
         4, 5: return CMD_FUNC | (r & 8'h1D) | (($urandom_range(0, 5) != 0) ? FS_GRAPH : 8'h00);
         6:  return CMD_CGRAM | (r & 8'h3F);
         7, 8: return CMD_DDRAM | (r & 8'h7F);
         9:  return CMD_STANDBY | (r & 8'h01);
         10: return CMD_SCROLL | (r & 8'h01);
         11: return CMD_REVERSE | (r & 8'h03);
         12: return 8'h00;
         default: return r;
      endcase
   endfunction

   function automatic byte_type rand_data();
      case ($urandom_range(0, 19))
         0, 1, 2:    return 8'h00;
         3, 4:       return 8'($urandom_range(0, 7));
         5, 6, 7:    return 8'($urandom);
         default:    return 8'($urandom_range(CHAR_LO, CHAR_HI));
      endcase
   endfunction

   task automatic add_row(input logic op, input byte_type sb, input bit typed,
                          input pix_type want);
      row_type r;
      r.op = op;
      r.sb = sb;
      r.fc = 7'h7F;
      r.fr = 4'hF;
      r.fb = 8'hFF;
      r.typed = typed;
      r.want = want;
      dir_rows.push_back(r);
   endtask

   task automatic add_pair(input byte_type v, input bit typed, input pix_type want);
      pix_type none;
      none = '0;
      add_row(OP_LINK, {v[7:4], 4'h0}, 0, none);
      add_row(OP_LINK, {v[3:0], 4'h0}, typed, want);
   endtask

   // ---------------------------------------------------------- main sequence
   initial begin
      pix_type none;
      pix_type w;
      int   blk;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_LINK;
      req_serial_byte = '0;
      req_font_char = '0;
      req_font_row = '0;
      req_font_bits = '0;
      rsp_stall = 1'b0;
      pred_reset();
      for (int i = 0; i < FONT_DEPTH; i++) font_mem[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // glyphs of every character the bench writes; space is blank
      for (int c = 0; c < FONT_GLYPHS; c++)
         if (drawable(8'(c + CHAR_LO)))
            for (int r = 0; r < 16; r++)
               send_req(OP_FONT, 8'($urandom), 7'(c), 4'(r),
                        (c == 0) ? 8'h00 : 8'($urandom), 0, none);

      // directed list
      add_row(OP_FONT, 8'h00, 0, none);           // glyph index out of range, ignored
      add_row(OP_LINK, SYNC_WCMD, 0, none);
      add_pair(CMD_FUNC | FS_RE | FS_GRAPH | 8'h10, 0, none);
      add_pair(CMD_GDRAM, 0, none);               // row 0
      add_pair(CMD_GDRAM, 0, none);               // column 0
      add_row(OP_LINK, SYNC_WDATA, 0, none);
      w = '{x: 4'd0, y: 6'd0, bits: 8'hFF, lastrun: 1'b1};
      add_pair(8'hFF, 1, w);                      // all-ones graphic over blank text
      w = '{x: 4'd1, y: 6'd0, bits: 8'h00, lastrun: 1'b1};
      add_pair(8'h00, 1, w);
      add_row(OP_LINK, SYNC_WCMD, 0, none);
      add_pair(CMD_FUNC | FS_GRAPH | 8'h10, 0, none);  // back to the basic set
      add_pair(CMD_DDRAM | 8'h10, 0, none);
      add_row(OP_LINK, SYNC_WDATA, 0, none);
      add_pair(CHAR_HI, 0, none);                 // highest printable character
      add_pair(8'h00, 0, none);
      add_pair(8'h7F, 0, none);                   // out-of-range character
      add_pair(8'h00, 0, none);                   // glyph cell pair
      add_pair(8'hFF, 0, none);                   // glyph selector masked
      add_row(OP_LINK, SYNC_RDATA, 0, none);
      add_pair(8'h41, 0, none);                   // read mode drops the byte
      foreach (dir_rows[i])
         send_req(dir_rows[i].op, dir_rows[i].sb, dir_rows[i].fc, dir_rows[i].fr,
                  dir_rows[i].fb, dir_rows[i].typed, dir_rows[i].want);

      // random sequences, mostly well formed
      rand_cnt = 0;
      while (rand_cnt < N_RANDOM) begin
         blk = $urandom_range(0, 19);
         if (blk < 2) begin
            send_font(7'($urandom));
         end else if (blk < 4) begin
            send_link(8'($urandom));              // raw noise
         end else if (blk < 9) begin
            send_link(SYNC_WCMD);
            repeat ($urandom_range(1, 3)) send_pair(rand_command());
         end else if (blk < 11) begin
            // graphic address then graphic data
            send_link(SYNC_WCMD);
            send_pair(CMD_FUNC | FS_RE | FS_GRAPH);
            send_pair(CMD_GDRAM | 8'($urandom));
            send_pair(CMD_GDRAM | 8'($urandom));
            send_link(SYNC_WDATA);
            repeat ($urandom_range(1, 4)) send_pair(8'($urandom));
         end else if (blk < 18) begin
            send_link(SYNC_WDATA);
            repeat ($urandom_range(1, 4)) send_pair(rand_data());
            if ($urandom_range(0, 3) == 0) send_link(carrier(4'($urandom)));
         end else begin
            send_link(($urandom_range(0, 1) == 0) ? SYNC_RCMD : SYNC_RDATA);
            send_pair(8'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (pending_pix.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------- receiver
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cnt > 0) begin
            rsp_stall <= 1'b1;
            hold_cnt--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 14);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // checker: every pixel byte against the oldest expectation
   always @(posedge clock) begin
      pix_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pix.size() == 0) begin
            $display("%0t unexpected pixel byte x=%0d y=%0d bits=%h last=%b", $time,
                     rsp_x_byte, rsp_y_pixel, rsp_pixel_bits, rsp_last_of_run);
            errors++;
         end else begin
            e = pending_pix.pop_front();
            if (rsp_x_byte !== e.x) begin
               $display("%0t x_byte exp %0d got %0d", $time, e.x, rsp_x_byte);
               errors++;
            end
            if (rsp_y_pixel !== e.y) begin
               $display("%0t y_pixel exp %0d got %0d", $time, e.y, rsp_y_pixel);
               errors++;
            end
            if (rsp_pixel_bits !== e.bits) begin
               $display("%0t pixel_bits exp %h got %h", $time, e.bits, rsp_pixel_bits);
               errors++;
            end
            if (rsp_last_of_run !== e.lastrun) begin
               $display("%0t last_of_run exp %b got %b", $time, e.lastrun, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
